### rtl/mrdt_pkg.sv
// ----------------------------------------------------------------------------
// mrdt_pkg
// Shared types and codes for the mesh route-discovery table unit.
// ----------------------------------------------------------------------------
package mrdt_pkg;

    // item kinds
    localparam logic [1:0] T_REQUEST   = 2'd0;
    localparam logic [1:0] T_REPLY     = 2'd1;
    localparam logic [1:0] T_ORIGINATE = 2'd2;
    localparam logic [1:0] T_EXPIRE    = 2'd3;

    // verdict codes
    localparam logic [2:0] V_NONE      = 3'd0;
    localparam logic [2:0] V_DUPLICATE = 3'd1;
    localparam logic [2:0] V_REPLY_DST = 3'd2;
    localparam logic [2:0] V_REBCAST   = 3'd3;
    localparam logic [2:0] V_INSTALLED = 3'd4;
    localparam logic [2:0] V_FORWARD   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SELF_ADDR = 2'd0;
    localparam logic [1:0] CFG_IS_ROUTER = 2'd1;
    localparam logic [1:0] CFG_LIFETIME  = 2'd2;

    // configuration reset values
    localparam logic [15:0] SELF_ADDR_RST = 16'h0000;
    localparam logic        IS_ROUTER_RST = 1'b1;
    localparam logic [31:0] LIFETIME_RST  = 32'd10000;

    localparam logic [15:0] NO_NEXT_HOP = 16'hFFFF;

    // route status codes
    localparam logic ST_ACTIVE   = 1'b0;
    localparam logic ST_UNDERWAY = 1'b1;

    // one discovery table entry
    typedef struct packed {
        logic [23:0] key;
        logic [15:0] back_hop;
        logic [7:0]  cost;
        logic [31:0] expiry;
    } t_entry;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic finish;
    } t_dp_cmd;

endpackage

### rtl/mrdt_ctrl.sv
// ----------------------------------------------------------------------------
// mrdt_ctrl
// Sequencer: accepts a word, sweeps the table one entry per cycle, then
// tells the datapath to commit and present the result.
// ----------------------------------------------------------------------------
module mrdt_ctrl #(
    parameter int DISCOVERY_ENTRIES = 8,
    parameter int IW                = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output mrdt_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]    o_rd_addr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    localparam logic [IW-1:0] LAST_IDX = IW'(DISCOVERY_ENTRIES - 1);

    t_state        r_state;
    logic [IW-1:0] r_cnt;
    logic          r_busy;

    // state, sweep counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_busy  <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // command decode
    assign busy          = r_busy;
    assign o_cmd.capture = start && !r_busy;
    assign o_cmd.rd_en   = (r_state == S_SCAN);
    assign o_cmd.finish  = (r_state == S_FINISH);
    assign o_rd_addr     = r_cnt;

`ifndef SYNTHESIS
    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && (r_state == S_SCAN) && (r_cnt == '0))
        else $error("accepted word did not start a sweep");

    a_finish_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> !busy)
        else $error("busy held after commit");

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");
`endif

endmodule

### rtl/mrdt_dp.sv
// ----------------------------------------------------------------------------
// mrdt_dp
// Datapath: configuration registers, discovery table memory with used bits,
// sweep accumulators (lookup, free slot, oldest slot) and result registers.
// ----------------------------------------------------------------------------
module mrdt_dp #(
    parameter int DISCOVERY_ENTRIES = 8,
    parameter int IW                = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrdt_pkg::t_dp_cmd i_cmd,
    input  logic [IW-1:0]     i_rd_addr,
    // configuration
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    // input word
    input  logic [1:0]        i_req_type,
    input  logic              i_frame_valid,
    input  logic [15:0]       i_previous_hop,
    input  logic [15:0]       i_originator,
    input  logic [7:0]        i_request_id,
    input  logic [15:0]       i_destination,
    input  logic [15:0]       i_responder,
    input  logic [7:0]        i_path_cost_in,
    input  logic [7:0]        i_link_cost,
    input  logic [31:0]       i_now_ms,
    // result word
    output logic              o_result_valid,
    output logic [2:0]        o_verdict,
    output logic [15:0]       o_send_to,
    output logic [7:0]        o_path_cost_out,
    output logic [7:0]        o_new_request_id,
    output logic              o_route_write,
    output logic [15:0]       o_route_dest,
    output logic [15:0]       o_route_next_hop,
    output logic              o_route_status
);

    // configuration
    logic [15:0] r_self_addr;
    logic        r_is_router;
    logic [31:0] r_lifetime;

    // table
    mrdt_pkg::t_entry r_mem [DISCOVERY_ENTRIES];
    mrdt_pkg::t_entry r_rd_data;
    logic [DISCOVERY_ENTRIES-1:0] r_used;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;
    logic [7:0]       r_req_cnt;

    // captured word
    logic [1:0]  r_type;
    logic        r_valid;
    logic [15:0] r_prev;
    logic [15:0] r_orig;
    logic [7:0]  r_rid;
    logic [15:0] r_dest;
    logic [15:0] r_resp;
    logic [7:0]  r_cost;
    logic [31:0] r_now;

    // sweep accumulators
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [7:0]    r_hit_cost;
    logic [15:0]   r_hit_back;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_exp;

    // result registers
    logic        r_out_valid;
    logic [2:0]  r_verdict;
    logic [15:0] r_send_to;
    logic [7:0]  r_pcost;
    logic [7:0]  r_newid;
    logic        r_wr;
    logic [15:0] r_rdest;
    logic [15:0] r_rhop;
    logic        r_rstat;

    // per-entry evaluation of the word coming out of the memory
    logic        cur_used;
    logic [31:0] age_diff;
    logic        hit_now;
    logic        free_now;
    logic        best_now;
    logic        expire_now;

    assign cur_used   = r_used[r_rd_idx];
    assign age_diff   = r_now - r_rd_data.expiry;
    assign hit_now    = r_rd_vld && !r_hit && cur_used
                        && (r_rd_data.key == {r_rid, r_orig});
    assign free_now   = r_rd_vld && !r_free_found && !cur_used;
    assign best_now   = r_rd_vld && ((r_rd_idx == '0)
                        || (cur_used && (r_rd_data.expiry < r_best_exp)));
    assign expire_now = r_rd_vld && (r_type == mrdt_pkg::T_EXPIRE)
                        && cur_used && !age_diff[31];

    // result computation from the finished sweep
    logic          own;
    logic          req_accept;
    logic [IW-1:0] slot;
    logic [7:0]    next_id;
    logic [2:0]    res_verdict;
    logic [15:0]   res_send_to;
    logic [7:0]    res_pcost;
    logic [7:0]    res_newid;
    logic          res_wr;
    logic [15:0]   res_rdest;
    logic [15:0]   res_rhop;
    logic          res_rstat;
    logic          commit_req;

    assign own        = !r_valid || (r_orig == r_self_addr);
    assign req_accept = !own && !(r_hit && (r_hit_cost <= r_cost));
    assign slot       = r_hit ? r_hit_idx : (r_free_found ? r_free_idx : r_best_idx);
    assign next_id    = r_req_cnt + 8'd1;
    assign commit_req = i_cmd.finish && (r_type == mrdt_pkg::T_REQUEST) && req_accept;

    always_comb begin
        res_verdict = mrdt_pkg::V_NONE;
        res_send_to = '0;
        res_pcost   = '0;
        res_newid   = '0;
        res_wr      = 1'b0;
        res_rdest   = '0;
        res_rhop    = '0;
        res_rstat   = mrdt_pkg::ST_ACTIVE;
        case (r_type)
            mrdt_pkg::T_REQUEST: begin
                res_send_to = r_prev;
                if (!req_accept) begin
                    res_verdict = mrdt_pkg::V_DUPLICATE;
                end else begin
                    res_wr    = 1'b1;
                    res_rdest = r_orig;
                    res_rhop  = r_prev;
                    if (r_dest == r_self_addr) begin
                        res_verdict = mrdt_pkg::V_REPLY_DST;
                    end else if (r_is_router) begin
                        res_verdict = mrdt_pkg::V_REBCAST;
                        res_pcost   = r_cost;
                    end
                end
            end
            mrdt_pkg::T_REPLY: begin
                if (r_valid) begin
                    res_pcost = r_cost;
                    if (r_orig == r_self_addr) begin
                        res_verdict = mrdt_pkg::V_INSTALLED;
                        res_wr      = 1'b1;
                        res_rdest   = r_resp;
                        res_rhop    = r_prev;
                    end else if (r_hit) begin
                        res_verdict = mrdt_pkg::V_FORWARD;
                        res_send_to = r_hit_back;
                        res_wr      = 1'b1;
                        res_rdest   = r_resp;
                        res_rhop    = r_prev;
                    end
                end
            end
            mrdt_pkg::T_ORIGINATE: begin
                res_newid = next_id;
                res_wr    = 1'b1;
                res_rdest = r_dest;
                res_rhop  = mrdt_pkg::NO_NEXT_HOP;
                res_rstat = mrdt_pkg::ST_UNDERWAY;
            end
            default: begin
            end
        endcase
    end

    // control state: config, used bits, counter, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_addr  <= mrdt_pkg::SELF_ADDR_RST;
            r_is_router  <= mrdt_pkg::IS_ROUTER_RST;
            r_lifetime   <= mrdt_pkg::LIFETIME_RST;
            r_used       <= '0;
            r_req_cnt    <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrdt_pkg::CFG_SELF_ADDR: r_self_addr <= i_cfg_data[15:0];
                    mrdt_pkg::CFG_IS_ROUTER: r_is_router <= i_cfg_data[0];
                    mrdt_pkg::CFG_LIFETIME:  r_lifetime  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_rd_vld    <= i_cmd.rd_en;
            r_out_valid <= i_cmd.finish;
            if (i_cmd.capture) begin
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                if (free_now) begin
                    r_free_found <= 1'b1;
                end
            end
            // expire tick frees stale entries as the sweep passes them
            if (expire_now) begin
                r_used[r_rd_idx] <= 1'b0;
            end
            if (commit_req) begin
                r_used[slot] <= 1'b1;
            end
            if (i_cmd.finish && (r_type == mrdt_pkg::T_ORIGINATE)) begin
                r_req_cnt <= next_id;
            end
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (commit_req) begin
            r_mem[slot] <= '{key:      {r_rid, r_orig},
                             back_hop: r_prev,
                             cost:     r_cost,
                             expiry:   r_now + r_lifetime};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        r_rd_idx <= i_rd_addr;
    end

    // captured word, sweep payload and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_req_type;
            r_valid <= i_frame_valid;
            r_prev  <= i_previous_hop;
            r_orig  <= i_originator;
            r_rid   <= i_request_id;
            r_dest  <= i_destination;
            r_resp  <= i_responder;
            r_cost  <= i_path_cost_in + i_link_cost;
            r_now   <= i_now_ms;
        end
        if (hit_now) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_cost <= r_rd_data.cost;
            r_hit_back <= r_rd_data.back_hop;
        end
        if (free_now) begin
            r_free_idx <= r_rd_idx;
        end
        if (best_now) begin
            r_best_idx <= r_rd_idx;
            r_best_exp <= r_rd_data.expiry;
        end
        if (i_cmd.finish) begin
            r_verdict <= res_verdict;
            r_send_to <= res_send_to;
            r_pcost   <= res_pcost;
            r_newid   <= res_newid;
            r_wr      <= res_wr;
            r_rdest   <= res_rdest;
            r_rhop    <= res_rhop;
            r_rstat   <= res_rstat;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_send_to        = r_send_to;
    assign o_path_cost_out  = r_pcost;
    assign o_new_request_id = r_newid;
    assign o_route_write    = r_wr;
    assign o_route_dest     = r_rdest;
    assign o_route_next_hop = r_rhop;
    assign o_route_status   = r_rstat;

`ifndef SYNTHESIS
    a_finish_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_result_valid)
        else $error("commit without result strobe");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_dup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_verdict == mrdt_pkg::V_DUPLICATE) |-> !o_route_write)
        else $error("duplicate verdict carries a route write");
`endif

endmodule

### rtl/mesh_route_discovery_table_unit.sv
// ----------------------------------------------------------------------------
// mesh_route_discovery_table_unit
// Route-discovery engine for a mesh node: request/reply/originate/expire.
// ----------------------------------------------------------------------------
// Usage
//   command channel: drive a word on the i_ ports with start high; it is
//   taken at an edge where busy is low. One result word follows, shown on
//   the o_ ports for one cycle with o_result_valid high.
//   configuration channel: i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 self address, 1 router flag, 2 lifetime in ms.
//   o_cfg_ready is always high; write only while the block is idle.
// Sequencing
//   each word sweeps the discovery table through its single read port, one
//   entry per cycle, then passes the drain state and commits in the finish
//   state; the result strobe is registered from that commit, and busy drops
//   in the same cycle as the strobe, so a new word is taken only once the
//   last one is through.
// Reset
//   synchronous, active low; all entries become free, the request counter
//   clears, configuration returns to its defaults. No clearing pass.
// The receiver cannot stall; each result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module mesh_route_discovery_table_unit #(
    parameter int DISCOVERY_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic        i_frame_valid,
    input  logic [15:0] i_previous_hop,
    input  logic [15:0] i_originator,
    input  logic [7:0]  i_request_id,
    input  logic [15:0] i_destination,
    input  logic [15:0] i_responder,
    input  logic [7:0]  i_path_cost_in,
    input  logic [7:0]  i_link_cost,
    input  logic [31:0] i_now_ms,
    // result channel
    output logic        o_result_valid,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_send_to,
    output logic [7:0]  o_path_cost_out,
    output logic [7:0]  o_new_request_id,
    output logic        o_route_write,
    output logic [15:0] o_route_dest,
    output logic [15:0] o_route_next_hop,
    output logic        o_route_status,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = (DISCOVERY_ENTRIES > 1) ? $clog2(DISCOVERY_ENTRIES) : 1;

    mrdt_pkg::t_dp_cmd cmd;
    logic [IW-1:0]     rd_addr;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    mrdt_ctrl #(
        .DISCOVERY_ENTRIES (DISCOVERY_ENTRIES),
        .IW                (IW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr)
    );

    mrdt_dp #(
        .DISCOVERY_ENTRIES (DISCOVERY_ENTRIES),
        .IW                (IW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_frame_valid    (i_frame_valid),
        .i_previous_hop   (i_previous_hop),
        .i_originator     (i_originator),
        .i_request_id     (i_request_id),
        .i_destination    (i_destination),
        .i_responder      (i_responder),
        .i_path_cost_in   (i_path_cost_in),
        .i_link_cost      (i_link_cost),
        .i_now_ms         (i_now_ms),
        .o_result_valid   (o_result_valid),
        .o_verdict        (o_verdict),
        .o_send_to        (o_send_to),
        .o_path_cost_out  (o_path_cost_out),
        .o_new_request_id (o_new_request_id),
        .o_route_write    (o_route_write),
        .o_route_dest     (o_route_dest),
        .o_route_next_hop (o_route_next_hop),
        .o_route_status   (o_route_status)
    );

endmodule
